// ===== hdl/polar_ring_bilinear_sampler_macros.svh =====
// Assertion macros shared by the polar ring sampler checks
`ifndef POLAR_RING_BILINEAR_SAMPLER_MACROS_SVH
`define POLAR_RING_BILINEAR_SAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PRBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PRBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/prbs_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the polar ring sampler
`default_nettype none

package prbs_pkg;

    // Field widths
    localparam int IDX_W     = 10;
    localparam int RAD_W     = 8;
    localparam int COORD8_W  = 8;
    localparam int VAL_W     = 16;
    localparam int RLEN_W    = 10;
    localparam int LEN_W     = 11;
    localparam int PHASE_W   = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     DIM_RESET        = 9'd256;

    // Ring length: pi in Q24
    localparam logic [25:0] PI_Q24 = 26'd52707179;
    localparam logic [RLEN_W-1:0] RLEN_SAT = 10'd1023;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 28;
    localparam int CV_W = 34;
    localparam int CZ_W = 32;
    localparam logic signed [CV_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Product of a Q30 sine/cosine and the radius
    localparam int PROD_W = CV_W + RAD_W + 1;

    // Word carried alongside the datapath
    typedef struct packed {
        logic                   is_sample;
        logic [COORD8_W-1:0]    px;
        logic [COORD8_W-1:0]    py;
        logic [VAL_W-1:0]       pv;
        logic [RAD_W-1:0]       rad;
        logic [RLEN_W-1:0]      rlen;
        logic                   oor;
    } side_t;

    // Arctangent of 2^-k in units of 2^-32 turn
    function automatic logic signed [CZ_W-1:0] cordic_atan(input int k);
        logic signed [CZ_W-1:0] a;
        case (k)
            0:  a = 32'sd536870912;
            1:  a = 32'sd316933406;
            2:  a = 32'sd167458907;
            3:  a = 32'sd85004756;
            4:  a = 32'sd42667331;
            5:  a = 32'sd21354465;
            6:  a = 32'sd10679838;
            7:  a = 32'sd5340245;
            8:  a = 32'sd2670163;
            9:  a = 32'sd1335087;
            10: a = 32'sd667544;
            11: a = 32'sd333772;
            12: a = 32'sd166886;
            13: a = 32'sd83443;
            14: a = 32'sd41722;
            15: a = 32'sd20861;
            16: a = 32'sd10430;
            17: a = 32'sd5215;
            18: a = 32'sd2608;
            19: a = 32'sd1304;
            20: a = 32'sd652;
            21: a = 32'sd326;
            22: a = 32'sd163;
            23: a = 32'sd81;
            24: a = 32'sd41;
            25: a = 32'sd20;
            26: a = 32'sd10;
            27: a = 32'sd5;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/polar_ring_bilinear_sampler.sv =====
// Polar ring bilinear sampler: top level
//
// Request channel (req_valid / req_stall): func 0 writes pixel_value to the
// store at (pixel_x, pixel_y); func 1 asks for one sample on the ring of
// the given radius at sample_index. Result channel (res_valid / res_stall):
// one word per sample request, none per pixel load, in request order.
// Configuration: cfg_write with cfg_index 0 sets image_width, 1 sets
// image_height; write only while no request is in flight.
// From request acceptance to res_valid a request passes the 32-stage phase
// divider, the 28-stage CORDIC and the banked store read.
// Throughput: one request per cycle unless stalled; the four neighbors come
// from four store banks split by x and y parity, each read once per sample.
// Reset clears the pipeline valids and sets both image sizes to 256; the
// image store is not cleared, so pixels must be loaded before sampling.
// A stalled result word holds and the whole pipeline freezes with it;
// req_stall rises in the same cycle.
`default_nettype none

module polar_ring_bilinear_sampler
    import prbs_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic                   func,
    input  wire logic [COORD8_W-1:0]    pixel_x,
    input  wire logic [COORD8_W-1:0]    pixel_y,
    input  wire logic signed [VAL_W-1:0] pixel_value,
    input  wire logic [RAD_W-1:0]       radius,
    input  wire logic [IDX_W-1:0]       sample_index,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output logic signed [VAL_W-1:0]     sample_value,
    output logic [RLEN_W-1:0]           ring_length,
    output logic                        index_out_of_range,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int PIX_W = (PIXEL_BITS < VAL_W) ? PIXEL_BITS : VAL_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic adv;
    logic res_valid_reg;
    assign adv       = !(res_valid_reg && res_stall);
    assign req_stall = !adv;

    // Configuration registers
    logic [CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective image size: zero reads as one, large values cap at MAX_DIM
    logic [DIM_W-1:0] img_w, img_h;

    always_comb
    begin
        if (width_reg == '0)
            img_w = DIM_W'(1);
        else if (32'(width_reg) > 32'(MAX_DIM))
            img_w = DIM_W'(MAX_DIM);
        else
            img_w = DIM_W'(width_reg);
        if (height_reg == '0)
            img_h = DIM_W'(1);
        else if (32'(height_reg) > 32'(MAX_DIM))
            img_h = DIM_W'(MAX_DIM);
        else
            img_h = DIM_W'(height_reg);
    end

    // Input stage: capture the word and the ring length
    logic               a_valid_reg;
    side_t              a_side_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic [LEN_W-1:0]   a_len_reg;
    logic [33:0]        len_prod;

    assign len_prod = 34'(radius) * 34'(PI_Q24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg.is_sample <= func;
            a_side_reg.px        <= pixel_x;
            a_side_reg.py        <= pixel_y;
            a_side_reg.pv        <= pixel_value;
            a_side_reg.rad       <= radius;
            a_side_reg.rlen      <= '0;
            a_side_reg.oor       <= 1'b0;
            a_idx_reg            <= sample_index;
            a_len_reg            <= {len_prod[33:24], 1'b0};
        end
    end

    // Range check and saturated length ride along with the item
    side_t div_side;

    always_comb
    begin
        div_side      = a_side_reg;
        div_side.rlen = (a_len_reg > LEN_W'(RLEN_SAT)) ? RLEN_SAT : a_len_reg[RLEN_W-1:0];
        div_side.oor  = {1'b0, a_idx_reg} >= a_len_reg;
    end

    logic               dv_valid;
    side_t              dv_side;
    logic [PHASE_W-1:0] dv_phase;

    prbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_side   (div_side),
        .dividend  (a_idx_reg),
        .divisor   (a_len_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quotient  (dv_phase)
    );

    logic                   cr_valid;
    side_t                  cr_side;
    logic signed [CV_W-1:0] cr_nsin, cr_cos;

    prbs_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dv_valid),
        .in_side   (dv_side),
        .phase     (dv_phase),
        .out_valid (cr_valid),
        .out_side  (cr_side),
        .neg_sin   (cr_nsin),
        .cosine    (cr_cos)
    );

    // Scale by the radius
    logic                     c_valid_reg;
    side_t                    c_side_reg;
    logic signed [PROD_W-1:0] c_px_reg, c_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= cr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_side_reg <= cr_side;
            c_px_reg   <= cr_nsin * $signed({1'b0, cr_side.rad});
            c_py_reg   <= cr_cos * $signed({1'b0, cr_side.rad});
        end
    end

    logic                    ip_valid;
    side_t                   ip_side;
    logic signed [VAL_W-1:0] ip_value;

    prbs_interp #(
        .MAX_DIM (MAX_DIM),
        .PIX_W   (PIX_W)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .in_side   (c_side_reg),
        .prod_x    (c_px_reg),
        .prod_y    (c_py_reg),
        .img_w     (img_w),
        .img_h     (img_h),
        .out_valid (ip_valid),
        .out_side  (ip_side),
        .out_value (ip_value)
    );

    // Result register
    logic signed [VAL_W-1:0] value_reg;
    logic [RLEN_W-1:0]       rlen_reg;
    logic                    oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= ip_valid && ip_side.is_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= ip_side.oor ? '0 : ip_value;
            rlen_reg  <= ip_side.rlen;
            oor_reg   <= ip_side.oor;
        end
    end

    assign res_valid          = res_valid_reg;
    assign sample_value       = value_reg;
    assign ring_length        = rlen_reg;
    assign index_out_of_range = oor_reg;

endmodule

`default_nettype wire

// ===== hdl/prbs_div.sv =====
// Pipelined restoring divider: phase = floor(index * 2^32 / length), one bit per stage
`default_nettype none

module prbs_div
    import prbs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire side_t              in_side,
    input  wire logic [IDX_W-1:0]   dividend,
    input  wire logic [LEN_W-1:0]   divisor,
    output logic                    out_valid,
    output side_t                   out_side,
    output logic [PHASE_W-1:0]      quotient
);

    logic [LEN_W-1:0]   rem_reg  [PHASE_W];
    logic [LEN_W-1:0]   len_reg  [PHASE_W];
    logic [PHASE_W-1:0] q_reg    [PHASE_W];
    side_t              side_reg [PHASE_W];
    logic               vld_reg  [PHASE_W];

    for (genvar k = 0; k < PHASE_W; k++) begin : g_step
        logic [LEN_W-1:0]   rem_cur;
        logic [LEN_W-1:0]   len_cur;
        logic [PHASE_W-1:0] q_cur;
        side_t              side_cur;
        logic               vld_cur;
        logic [LEN_W:0]     shifted;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_cur  = LEN_W'(dividend);
            assign len_cur  = divisor;
            assign q_cur    = '0;
            assign side_cur = in_side;
            assign vld_cur  = in_valid;
        end else begin : g_next
            assign rem_cur  = rem_reg[k-1];
            assign len_cur  = len_reg[k-1];
            assign q_cur    = q_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // Trial subtract of the doubled remainder
        assign shifted = {rem_cur, 1'b0};
        assign ge      = shifted >= {1'b0, len_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? LEN_W'(shifted - {1'b0, len_cur}) : shifted[LEN_W-1:0];
                len_reg[k]  <= len_cur;
                q_reg[k]    <= {q_cur[PHASE_W-2:0], ge};
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[PHASE_W-1];
    assign out_side  = side_reg[PHASE_W-1];
    assign quotient  = q_reg[PHASE_W-1];

endmodule

`default_nettype wire

// ===== hdl/prbs_cordic.sv =====
// Pipelined CORDIC: one rotation per stage, then a quadrant fold to -sin and cos in Q30
`default_nettype none

module prbs_cordic
    import prbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire side_t                  in_side,
    input  wire logic [PHASE_W-1:0]     phase,
    output logic                        out_valid,
    output side_t                       out_side,
    output logic signed [CV_W-1:0]      neg_sin,
    output logic signed [CV_W-1:0]      cosine
);

    logic signed [CV_W-1:0] vx_reg   [CORDIC_STEPS];
    logic signed [CV_W-1:0] vy_reg   [CORDIC_STEPS];
    logic signed [CZ_W-1:0] z_reg    [CORDIC_STEPS];
    logic [1:0]             quad_reg [CORDIC_STEPS];
    side_t                  side_reg [CORDIC_STEPS];
    logic                   vld_reg  [CORDIC_STEPS];

    logic signed [CV_W-1:0] nsin_reg, nsin_next;
    logic signed [CV_W-1:0] cos_reg, cos_next;
    side_t                  oside_reg;
    logic                   ovld_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        logic signed [CV_W-1:0] vx_cur, vy_cur, tx, ty;
        logic signed [CZ_W-1:0] z_cur;
        logic [1:0]             quad_cur;
        side_t                  side_cur;
        logic                   vld_cur;
        logic                   zneg;

        if (k == 0) begin : g_first
            assign vx_cur   = CORDIC_GAIN_Q30;
            assign vy_cur   = '0;
            assign z_cur    = $signed({2'b00, phase[PHASE_W-3:0]});
            assign quad_cur = phase[PHASE_W-1:PHASE_W-2];
            assign side_cur = in_side;
            assign vld_cur  = in_valid;
        end else begin : g_next
            assign vx_cur   = vx_reg[k-1];
            assign vy_cur   = vy_reg[k-1];
            assign z_cur    = z_reg[k-1];
            assign quad_cur = quad_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        assign tx   = vx_cur >>> k;
        assign ty   = vy_cur >>> k;
        assign zneg = z_cur[CZ_W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        // Rotate toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vx_reg[k]   <= zneg ? vx_cur + ty : vx_cur - ty;
                vy_reg[k]   <= zneg ? vy_cur - tx : vy_cur + tx;
                z_reg[k]    <= zneg ? z_cur + cordic_atan(k) : z_cur - cordic_atan(k);
                quad_reg[k] <= quad_cur;
                side_reg[k] <= side_cur;
            end
        end
    end

    // Quadrant fold
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                nsin_next = -vy_reg[CORDIC_STEPS-1];
                cos_next  = vx_reg[CORDIC_STEPS-1];
            end
            2'd1:
            begin
                nsin_next = -vx_reg[CORDIC_STEPS-1];
                cos_next  = -vy_reg[CORDIC_STEPS-1];
            end
            2'd2:
            begin
                nsin_next = vy_reg[CORDIC_STEPS-1];
                cos_next  = -vx_reg[CORDIC_STEPS-1];
            end
            default:
            begin
                nsin_next = vx_reg[CORDIC_STEPS-1];
                cos_next  = vy_reg[CORDIC_STEPS-1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            ovld_reg <= vld_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nsin_reg  <= nsin_next;
            cos_reg   <= cos_next;
            oside_reg <= side_reg[CORDIC_STEPS-1];
        end
    end

    assign out_valid = ovld_reg;
    assign out_side  = oside_reg;
    assign neg_sin   = nsin_reg;
    assign cosine    = cos_reg;

endmodule

`default_nettype wire

// ===== hdl/prbs_interp.sv =====
// Banked image store, edge clamp and bilinear interpolation pipeline
`default_nettype none

module prbs_interp
    import prbs_pkg::*;
#(
    parameter  int MAX_DIM = 256,
    parameter  int PIX_W   = 16,
    localparam int DIM_W   = $clog2(MAX_DIM + 1)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire side_t                      in_side,
    input  wire logic signed [PROD_W-1:0]   prod_x,
    input  wire logic signed [PROD_W-1:0]   prod_y,
    input  wire logic [DIM_W-1:0]           img_w,
    input  wire logic [DIM_W-1:0]           img_h,
    output logic                            out_valid,
    output side_t                           out_side,
    output logic signed [VAL_W-1:0]         out_value
);

    localparam int CW         = DIM_W + 18;
    localparam int XLW        = CW - 16;
    localparam int AB         = $clog2(MAX_DIM) - 1;
    localparam int BANK_DEPTH = 1 << (2 * AB);
    localparam int WT_W       = 33;
    localparam int GP_W       = PIX_W + WT_W + 1;
    localparam int ACC_W      = GP_W + 2;
    localparam int RND_W      = ACC_W - 32;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'h8000_0000);

    typedef struct packed {
        logic signed [XLW-1:0] fl;
        logic [15:0]           fr;
        logic                  v0;
        logic                  v1;
    } axis_t;

    // Snap a coordinate just past the edge onto it, split it and check both neighbors
    function automatic axis_t axis_split(input logic signed [CW-1:0] c,
                                         input logic [DIM_W-1:0] dim);
        logic signed [XLW-1:0] fl;
        logic signed [XLW-1:0] dimx;
        logic signed [XLW-1:0] dm1;
        logic [15:0]           fr;
        axis_t                 res;
        fl   = c[CW-1:16];
        fr   = c[15:0];
        dimx = $signed({2'b00, dim});
        dm1  = dimx - XLW'(1);
        if (&c[CW-1:16])
        begin
            fl = '0;
            fr = '0;
        end
        else if ((fl == dm1 && fr != 16'd0) || (fl == dimx && fr == 16'd0))
        begin
            fl = dm1;
            fr = '0;
        end
        res.fl = fl;
        res.fr = fr;
        res.v0 = !fl[XLW-1] && (fl < dimx);
        res.v1 = (!fl[XLW-1] || (&fl)) && (fl < dm1);
        return res;
    endfunction

    // Stage 1: round and add the image center
    logic                  s1_valid_reg;
    side_t                 s1_side_reg;
    logic signed [CW-1:0]  s1_x_reg, s1_x_next;
    logic signed [CW-1:0]  s1_y_reg, s1_y_next;

    always_comb
    begin
        logic signed [PROD_W-1:0] rx;
        logic signed [PROD_W-1:0] ry;
        rx = (prod_x + PROD_W'(8192)) >>> 14;
        ry = (prod_y + PROD_W'(8192)) >>> 14;
        s1_x_next = $signed({3'b000, img_w, 15'd0}) + rx[CW-1:0];
        s1_y_next = $signed({3'b000, img_h, 15'd0}) + ry[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= in_side;
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
        end
    end

    // Stage 2: clamp, floor and bank addresses
    axis_t ax, ay;
    assign ax = axis_split(s1_x_reg, img_w);
    assign ay = axis_split(s1_y_reg, img_h);

    logic           s2_valid_reg;
    side_t          s2_side_reg;
    axis_t          s2_ax_reg, s2_ay_reg;
    logic [AB-1:0]  s2_col_even_reg, s2_col_odd_reg;
    logic [AB-1:0]  s2_row_even_reg, s2_row_odd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg     <= s1_side_reg;
            s2_ax_reg       <= ax;
            s2_ay_reg       <= ay;
            s2_col_even_reg <= ax.fl[AB:1] + AB'(ax.fl[0]);
            s2_col_odd_reg  <= ax.fl[AB:1];
            s2_row_even_reg <= ay.fl[AB:1] + AB'(ay.fl[0]);
            s2_row_odd_reg  <= ay.fl[AB:1];
        end
    end

    // Stage 3: four banks split by x and y parity; loads write here in order
    logic [31:0]        ld_x, ld_y;
    logic               ld_ok;
    logic [1:0]         ld_bank;
    logic [2*AB-1:0]    ld_addr;
    logic [PIX_W-1:0]   rd_reg [4];

    assign ld_x    = {24'd0, s2_side_reg.px};
    assign ld_y    = {24'd0, s2_side_reg.py};
    assign ld_ok   = (ld_x < 32'(MAX_DIM)) && (ld_y < 32'(MAX_DIM));
    assign ld_bank = {ld_y[0], ld_x[0]};
    assign ld_addr = {ld_y[AB:1], ld_x[AB:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] bank_mem [BANK_DEPTH];
        logic [2*AB-1:0]  rd_addr;
        logic             wr_en;

        assign rd_addr = {(b / 2 == 1) ? s2_row_odd_reg : s2_row_even_reg,
                          (b % 2 == 1) ? s2_col_odd_reg : s2_col_even_reg};
        assign wr_en   = en && s2_valid_reg && !s2_side_reg.is_sample && ld_ok
                         && (ld_bank == 2'(b));

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                bank_mem[ld_addr] <= s2_side_reg.pv[PIX_W-1:0];
            end
            if (en)
            begin
                rd_reg[b] <= bank_mem[rd_addr];
            end
        end
    end

    logic    s3_valid_reg;
    side_t   s3_side_reg;
    axis_t   s3_ax_reg, s3_ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s2_side_reg;
            s3_ax_reg   <= s2_ax_reg;
            s3_ay_reg   <= s2_ay_reg;
        end
    end

    // Stage 4: route banks to neighbors, mask outside pixels, form weights
    logic                    s4_valid_reg;
    side_t                   s4_side_reg;
    logic signed [PIX_W-1:0] s4_pix_reg [4];
    logic signed [PIX_W-1:0] s4_pix_next [4];
    logic [WT_W-1:0]         s4_wt_reg [4];
    logic [WT_W-1:0]         s4_wt_next [4];

    always_comb
    begin
        logic       xo, yo;
        logic [16:0] fx, fy, gx, gy;
        xo = s3_ax_reg.fl[0];
        yo = s3_ay_reg.fl[0];
        fx = {1'b0, s3_ax_reg.fr};
        fy = {1'b0, s3_ay_reg.fr};
        gx = 17'h10000 - fx;
        gy = 17'h10000 - fy;
        s4_pix_next[0] = (s3_ax_reg.v0 && s3_ay_reg.v0) ? $signed(rd_reg[{yo, xo}]) : '0;
        s4_pix_next[1] = (s3_ax_reg.v1 && s3_ay_reg.v0) ? $signed(rd_reg[{yo, !xo}]) : '0;
        s4_pix_next[2] = (s3_ax_reg.v0 && s3_ay_reg.v1) ? $signed(rd_reg[{!yo, xo}]) : '0;
        s4_pix_next[3] = (s3_ax_reg.v1 && s3_ay_reg.v1) ? $signed(rd_reg[{!yo, !xo}]) : '0;
        s4_wt_next[0]  = WT_W'(gx) * WT_W'(gy);
        s4_wt_next[1]  = WT_W'(fx) * WT_W'(gy);
        s4_wt_next[2]  = WT_W'(gx) * WT_W'(fy);
        s4_wt_next[3]  = WT_W'(fx) * WT_W'(fy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s3_side_reg;
            for (int i = 0; i < 4; i++)
            begin
                s4_pix_reg[i] <= s4_pix_next[i];
                s4_wt_reg[i]  <= s4_wt_next[i];
            end
        end
    end

    // Stage 5: weighted products
    logic                   s5_valid_reg;
    side_t                  s5_side_reg;
    logic signed [GP_W-1:0] s5_prod_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s4_side_reg;
            for (int i = 0; i < 4; i++)
            begin
                s5_prod_reg[i] <= s4_pix_reg[i] * $signed({1'b0, s4_wt_reg[i]});
            end
        end
    end

    // Sum, round half up to Q0 and saturate
    logic signed [ACC_W-1:0] acc;
    logic signed [RND_W-1:0] rnd;
    logic signed [PIX_W-1:0] sat;

    always_comb
    begin
        acc = ACC_W'(s5_prod_reg[0]) + ACC_W'(s5_prod_reg[1])
            + ACC_W'(s5_prod_reg[2]) + ACC_W'(s5_prod_reg[3]) + HALF;
        rnd = acc[ACC_W-1:32];
        if ((&rnd[RND_W-1:PIX_W-1]) || !(|rnd[RND_W-1:PIX_W-1]))
        begin
            sat = rnd[PIX_W-1:0];
        end
        else if (rnd[RND_W-1])
        begin
            sat = {1'b1, {(PIX_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(PIX_W-1){1'b1}}};
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_side  = s5_side_reg;
    assign out_value = VAL_W'(sat);

endmodule

`default_nettype wire

// ===== hdl/prbs_checker.sv =====
// Port-level checks for the polar ring sampler, bound to the top level
`default_nettype none
`include "polar_ring_bilinear_sampler_macros.svh"

module prbs_checker
    import prbs_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    req_stall,
    input wire logic                    res_valid,
    input wire logic                    res_stall,
    input wire logic signed [VAL_W-1:0] sample_value,
    input wire logic [RLEN_W-1:0]       ring_length,
    input wire logic                    index_out_of_range
);

    // A stalled result word stays and holds its payload
    `PRBS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "stalled result dropped")
    `PRBS_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(sample_value) && $stable(ring_length) && $stable(index_out_of_range), "stalled result changed")

    // The pipeline freezes behind a stalled result
    `PRBS_ASSERT_NOW(a_back_press, res_valid && res_stall, req_stall, "request taken while output blocked")

    // Out-of-range samples read as zero
    `PRBS_ASSERT_NOW(a_oor_zero, res_valid && index_out_of_range, sample_value == 16'sd0, "flagged sample not zero")

    // An in-range sample needs a ring of nonzero length
    `PRBS_ASSERT_NOW(a_len_nonzero, res_valid && !index_out_of_range, ring_length != 10'd0, "in-range sample on empty ring")

endmodule

bind polar_ring_bilinear_sampler prbs_checker u_prbs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_stall          (req_stall),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .sample_value       (sample_value),
    .ring_length        (ring_length),
    .index_out_of_range (index_out_of_range)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the polar ring bilinear sampler
`default_nettype none

module tb_top;
    import prbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One expected (or observed) sample word
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [RLEN_W-1:0]       rlen;
        logic                    oor;
    } sample_t;

    // One directed stimulus row; typed rows carry a hand-written answer
    typedef struct {
        bit              fn;
        bit [7:0]        px;
        bit [7:0]        py;
        bit [15:0]       pv;
        bit [7:0]        r;
        bit [9:0]        idx;
        bit              typed;
        bit [15:0]       ev;
        bit [9:0]        el;
        bit              eo;
    } row_t;

    localparam longint PI_FIX   = 52707179;
    localparam longint ONE_FIX  = 65536;
    localparam longint GAIN_FIX = 652032874;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic                    func = 1'b0;
    logic [COORD8_W-1:0]     pixel_x = '0;
    logic [COORD8_W-1:0]     pixel_y = '0;
    logic signed [VAL_W-1:0] pixel_value = '0;
    logic [RAD_W-1:0]        radius = '0;
    logic [IDX_W-1:0]        sample_index = '0;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic signed [VAL_W-1:0] sample_value;
    logic [RLEN_W-1:0]       ring_length;
    logic                    index_out_of_range;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    // Predictor state: image copy, written marks and size registers
    shortint     pixel_mem [65536];
    bit          loaded [65536];
    logic [8:0]  width_reg = 9'd256;
    logic [8:0]  height_reg = 9'd256;
    sample_t     pending_samples [$];
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          samples_seen = 0;
    int          loads_sent = 0;
    int          items_sent = 0;

    longint turn_table [28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    polar_ring_bilinear_sampler uut (.*);

    always #2 clk = ~clk;

    function automatic longint clip_dim(logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return longint'(v);
    endfunction

    function automatic longint ring_len(int unsigned r);
        return ((longint'(r) * PI_FIX) >>> 24) * 2;
    endfunction

    function automatic longint snap_edge(longint c, longint dim);
        if (c >= -ONE_FIX && c < 0) return 0;
        if (c > (dim - 1) * ONE_FIX && c <= dim * ONE_FIX) return (dim - 1) * ONE_FIX;
        return c;
    endfunction

    function automatic longint pixel_at(longint x, longint y, longint w, longint h);
        if (x < 0 || x >= w || y < 0 || y >= h) return 0;
        return longint'(pixel_mem[y * 256 + x]);
    endfunction

    // Clamped ring point in Q16 for an in-range index
    function automatic void ring_point(input int unsigned r, input int unsigned idx,
                                       input longint len, input longint w, input longint h,
                                       output longint x, output longint y);
        longint vx, vy, z, tx, ty, sn, cs;
        logic [63:0] ph;
        ph = (64'(idx) << 32) / 64'(len);
        vx = GAIN_FIX;
        vy = 0;
        z = longint'(ph & 64'h3FFF_FFFF);
        for (int i = 0; i < 28; i++) begin
            tx = vx >>> i;
            ty = vy >>> i;
            if (z >= 0) begin
                vx -= ty; vy += tx; z -= turn_table[i];
            end else begin
                vx += ty; vy -= tx; z += turn_table[i];
            end
        end
        case (ph[31:30])
            2'd0: begin sn = vy;  cs = vx;  end
            2'd1: begin sn = vx;  cs = -vy; end
            2'd2: begin sn = -vy; cs = -vx; end
            default: begin sn = -vx; cs = vy; end
        endcase
        x = snap_edge(w * 32768 + ((-sn * longint'(r) + 8192) >>> 14), w);
        y = snap_edge(h * 32768 + ((cs * longint'(r) + 8192) >>> 14), h);
    endfunction

    // Ring point lookup and bilinear blend, bit exact
    function automatic sample_t ring_sample(int unsigned r, int unsigned idx);
        sample_t s;
        longint len, w, h, x, y, xl, yl, fx, fy, acc, val;
        len = ring_len(r);
        s.rlen = (len > 1023) ? 10'd1023 : len[9:0];
        if (idx >= len) begin
            s.value = '0;
            s.oor = 1'b1;
            return s;
        end
        s.oor = 1'b0;
        w = clip_dim(width_reg);
        h = clip_dim(height_reg);
        ring_point(r, idx, len, w, h, x, y);
        xl = x >>> 16;
        yl = y >>> 16;
        fx = x & 65535;
        fy = y & 65535;
        acc = pixel_at(xl, yl, w, h) * ((ONE_FIX - fx) * (ONE_FIX - fy))
            + pixel_at(xl + 1, yl, w, h) * (fx * (ONE_FIX - fy))
            + pixel_at(xl, yl + 1, w, h) * ((ONE_FIX - fx) * fy)
            + pixel_at(xl + 1, yl + 1, w, h) * (fx * fy);
        val = (acc + (64'sd1 <<< 31)) >>> 32;
        if (val < -32768) val = -32768;
        if (val > 32767) val = 32767;
        s.value = val[15:0];
        return s;
    endfunction

    // Load any in-image neighbor of the ring point that was never written
    task automatic load_neighbors(input bit [7:0] r, input bit [9:0] idx);
        longint len, w, h, x, y, xl, yl, nx, ny;
        len = ring_len(r);
        if (idx >= len) return;
        w = clip_dim(width_reg);
        h = clip_dim(height_reg);
        ring_point(r, idx, len, w, h, x, y);
        xl = x >>> 16;
        yl = y >>> 16;
        for (int k = 0; k < 4; k++) begin
            nx = xl + (k % 2);
            ny = yl + (k / 2);
            if (nx >= 0 && nx < w && ny >= 0 && ny < h && !loaded[ny * 256 + nx])
                send_load(8'(nx), 8'(ny), 16'($urandom));
        end
    endtask

    // Present one request word, wait for acceptance, record its effect
    task automatic send_word(input bit fn, input bit [7:0] px, input bit [7:0] py,
                             input bit [15:0] pv, input bit [7:0] r, input bit [9:0] idx,
                             input bit typed, input sample_t ex);
        sample_t want;
        if (fn && !typed) load_neighbors(r, idx);
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= fn;
        pixel_x <= px;
        pixel_y <= py;
        pixel_value <= pv;
        radius <= r;
        sample_index <= idx;
        do @(posedge clk); while (req_stall);
        items_sent++;
        if (fn) begin
            want = typed ? ex : ring_sample(r, idx);
            pending_samples = {pending_samples, want};
        end else begin
            pixel_mem[int'(py) * 256 + int'(px)] = shortint'(pv);
            loaded[int'(py) * 256 + int'(px)] = 1'b1;
            loads_sent++;
        end
    endtask

    task automatic send_load(input bit [7:0] px, input bit [7:0] py, input bit [15:0] pv);
        sample_t none;
        send_word(1'b0, px, py, pv, 8'($urandom), 10'($urandom), 1'b0, none);
    endtask

    task automatic send_sample(input bit [7:0] r, input bit [9:0] idx);
        sample_t none;
        send_word(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), r, idx, 1'b0, none);
    endtask

    // Drain the pipeline, then write both size registers
    task automatic set_size(input bit [8:0] w, input bit [8:0] h);
        req_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    // Result checker and random receiver stall
    always @(posedge clk) begin
        sample_t want;
        if (rst_n && res_valid && !res_stall) begin
            samples_seen++;
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value %0d len %0d oor %0b",
                             sample_value, ring_length, index_out_of_range);
            end else begin
                want = pending_samples.pop_front();
                if (sample_value !== want.value || ring_length !== want.rlen
                    || index_out_of_range !== want.oor) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %0d len %0d oor %0b, got %0d %0d %0b",
                                 want.value, want.rlen, want.oor,
                                 sample_value, ring_length, index_out_of_range);
                end
            end
        end
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Directed rows: out-of-range cases first, needing no image
    row_t directed [] = '{
        '{1'b1, 8'd0, 8'd0, 16'h0000, 8'd0,   10'd0,    1'b1, 16'h0, 10'd0,    1'b1},
        '{1'b1, 8'd0, 8'd0, 16'h0000, 8'd1,   10'd6,    1'b1, 16'h0, 10'd6,    1'b1},
        '{1'b1, 8'd0, 8'd0, 16'h0000, 8'd128, 10'd1023, 1'b1, 16'h0, 10'd804,  1'b1},
        '{1'b1, 8'd0, 8'd0, 16'h0000, 8'd162, 10'd1020, 1'b1, 16'h0, 10'd1016, 1'b1},
        '{1'b0, 8'd0,   8'd0,   16'h8000, 8'd0, 10'd0, 1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b0, 8'd255, 8'd255, 16'h7FFF, 8'd0, 10'd0, 1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b0, 8'd128, 8'd129, 16'h7FFF, 8'd0, 10'd0, 1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b0, 8'd127, 8'd129, 16'h8000, 8'd0, 10'd0, 1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd1,   10'd0,    1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd1,   10'd3,    1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd1,   10'd5,    1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd128, 10'd0,    1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd128, 10'd201,  1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd128, 10'd402,  1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd128, 10'd603,  1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd128, 10'd803,  1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd163, 10'd1023, 1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd255, 10'd1023, 1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd200, 10'd0,    1'b0, 16'h0, 10'd0, 1'b0},
        '{1'b1, 8'd0, 8'd0, 16'h0, 8'd2,   10'd11,   1'b0, 16'h0, 10'd0, 1'b0}
    };

    // Size settings per phase, extremes and out-of-range register values included
    bit [8:0] phase_w [8] = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd17, 9'd256, 9'd5, 9'd128};
    bit [8:0] phase_h [8] = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd200, 9'd3, 9'd256, 9'd64};
    int       mode_idle  [4] = '{0, 61, 0, 35};
    int       mode_stall [4] = '{0, 0, 61, 35};

    // Main stimulus sequence
    initial begin
        sample_t ex;
        int      pick;
        int      stop;
        int      top_idx;
        bit [7:0] r;
        longint  len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // in-range samples load the pixels they touch just before they go out
        foreach (directed[k]) begin
            ex.value = directed[k].ev;
            ex.rlen = directed[k].el;
            ex.oor = directed[k].eo;
            send_word(directed[k].fn, directed[k].px, directed[k].py, directed[k].pv,
                      directed[k].r, directed[k].idx, directed[k].typed, ex);
        end

        // Random phases over sizes and idling and stalling modes
        for (int ph = 0; ph < 8; ph++) begin
            set_size(phase_w[ph], phase_h[ph]);
            idle_pct = mode_idle[ph % 4];
            stall_pct = mode_stall[ph % 4];
            stop = items_sent + 220;
            while (items_sent < stop) begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    send_load(8'($urandom), 8'($urandom), 16'($urandom));
                end else begin
                    r = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(128));
                    len = ring_len(r);
                    if (pick < 88 && len > 0) begin
                        top_idx = (len > 1023) ? 1023 : int'(len - 1);
                        send_sample(r, 10'($urandom_range(top_idx)));
                    end else begin
                        send_sample(r, 10'($urandom));
                    end
                end
            end
        end
        req_valid <= 1'b0;

        // Drain and let the pipeline settle
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d sample results and %0d pixel loads over 8 size settings",
                 samples_seen, loads_sent);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("[polar_ring_bilinear_sampler] OK");
        else
            $display("[polar_ring_bilinear_sampler] ERROR");
        $finish;
    end

    // Run limit
    initial begin
        #20ms;
        $display("timeout with %0d results still expected", pending_samples.size());
        $display("[polar_ring_bilinear_sampler] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/prbs_pkg.sv
hdl/prbs_div.sv
hdl/prbs_cordic.sv
hdl/prbs_interp.sv
hdl/polar_ring_bilinear_sampler.sv
hdl/prbs_checker.sv
tb/tb_top.sv
